// ===== src/psd_pkg.sv =====
// Shared types, constants and the max-star correction table for the PAM soft demapper.
package psd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CODE_W     = 4;
  localparam int LLR_W      = 16;
  localparam int LIMIT_W    = 15;
  localparam int MAX_BITS   = 4;
  localparam int BITS_W     = 3;
  localparam int NPTS       = 16;
  localparam int PT_W       = 4;
  localparam int BIT_W      = 2;
  localparam int Y_W        = SAMPLE_W + 4;
  localparam int X_W        = 23;
  localparam int AD_W       = 21;
  localparam int PROD_W     = 2 * AD_W;
  localparam int SUM_W      = 59;
  localparam int MET_SHIFT  = 31;
  localparam int MET_W      = 28;
  localparam int SCORE_W    = MET_W + 1;
  localparam int ACC_W      = 30;
  localparam int CORR_W     = 7;
  localparam int CORR_SHIFT = 6;
  localparam int CORR_DEPTH = 16;
  localparam int CORR_IDX_W = $clog2(CORR_DEPTH);

  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [SCORE_W-1:0] score_t;

  typedef enum logic [2:0] {
    REG_BITS  = 3'd0,
    REG_LABEL = 3'd1,
    REG_INV   = 3'd2,
    REG_STEP  = 3'd3,
    REG_LIMIT = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQUARE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SCORE,
    ST_COMBINE,
    ST_EMIT
  } state_t;

  // round(128 * ln(1 + exp(-k/2)))
  function automatic logic [CORR_W-1:0] corr_lookup(input logic [CORR_IDX_W-1:0] k);
    logic [CORR_W-1:0] v;
    case (k)
      4'd0:    v = 7'd89;
      4'd1:    v = 7'd61;
      4'd2:    v = 7'd40;
      4'd3:    v = 7'd26;
      4'd4:    v = 7'd16;
      4'd5:    v = 7'd10;
      4'd6:    v = 7'd6;
      4'd7:    v = 7'd4;
      4'd8:    v = 7'd2;
      4'd9:    v = 7'd1;
      4'd10:   v = 7'd1;
      4'd11:   v = 7'd1;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/pam_soft_demapper_top.sv =====
// PAM soft demapper: per-point distance metrics and per-bit max-star LLRs.
// Each symbol runs a sweep over its M = 2^b points, then one combine pass per bit,
// which an output stall can hold; the pace is set by the one shared 21x21 multiplier
// (five steps per point) and the one max-star unit (one point per cycle per bit).
// One LLR transaction per label bit, msb first; input ready only while idle.
// Synchronous active-high reset: configuration and control registers return to their reset values, datapath idle.
module pam_soft_demapper_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] sample, [19:16] code_bits, [23:20] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] llr
  output logic [1:0]  m_tuser,   // [1:0] bit_index
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // configuration registers
  logic [psd_pkg::BITS_W-1:0]  bits_per_symbol;
  logic [63:0]                 label_map;
  logic [15:0]                 inv_two_sigma2;
  logic [15:0]                 point_step;
  logic [psd_pkg::LIMIT_W-1:0] llr_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_symbol <= 3'd1;
      label_map       <= 64'hFEDC_BA98_7654_3210;
      inv_two_sigma2  <= 16'd256;
      point_step      <= 16'd32768;
      llr_limit       <= 15'd32767;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        psd_pkg::REG_BITS:  bits_per_symbol <= cfg_data[psd_pkg::BITS_W-1:0];
        psd_pkg::REG_LABEL: label_map       <= cfg_data;
        psd_pkg::REG_INV:   inv_two_sigma2  <= cfg_data[15:0];
        psd_pkg::REG_STEP:  point_step      <= cfg_data[15:0];
        psd_pkg::REG_LIMIT: llr_limit       <= cfg_data[psd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  psd_pkg::state_t           state, state_next;
  logic [psd_pkg::PT_W-1:0]  pt, pt_next;
  logic [psd_pkg::BIT_W-1:0] bit_i, bit_i_next;
  logic                      have0, have0_next;
  logic                      have1, have1_next;
  logic                      out_load;

  // datapath
  logic signed [psd_pkg::Y_W-1:0]   y;
  logic [psd_pkg::CODE_W-1:0]       code;
  logic [psd_pkg::BITS_W-1:0]       b_eff;
  logic signed [psd_pkg::X_W-1:0]   x;
  logic [psd_pkg::AD_W-1:0]         ad;
  logic [psd_pkg::PROD_W-1:0]       d2;
  logic [psd_pkg::PROD_W-1:0]       plo;
  logic [psd_pkg::PROD_W-1:0]       phi;
  psd_pkg::score_t                  score [psd_pkg::NPTS];
  psd_pkg::acc_t                    acc0;
  psd_pkg::acc_t                    acc1;

  logic [psd_pkg::BITS_W-1:0]       b_in;
  logic signed [psd_pkg::X_W-1:0]   step_ext;
  logic signed [psd_pkg::X_W-1:0]   x_init;
  logic signed [psd_pkg::X_W-1:0]   d;
  logic [psd_pkg::AD_W-1:0]         mul_a;
  logic [psd_pkg::AD_W-1:0]         mul_b;
  logic [psd_pkg::PROD_W-1:0]       prod;
  logic [psd_pkg::SUM_W-1:0]        sum;
  logic [psd_pkg::MET_W-1:0]        metric;
  logic [psd_pkg::PT_W-1:0]         pt_max;
  logic [psd_pkg::BIT_W-1:0]        bit_pos;
  logic [psd_pkg::BIT_W-1:0]        bit_last;
  logic [3:0]                       lab;
  logic                             lab_bit;
  psd_pkg::acc_t                    score_rd;
  psd_pkg::acc_t                    ms_y;
  logic signed [psd_pkg::ACC_W:0]   llr_wide;
  logic signed [psd_pkg::ACC_W:0]   lim_w;
  logic signed [psd_pkg::ACC_W:0]   llr_sat;
  logic [psd_pkg::LLR_W-1:0]        llr_out;

  always_comb begin
    if (bits_per_symbol == '0) begin
      b_in = 3'd1;
    end else if (bits_per_symbol > 3'(psd_pkg::MAX_BITS)) begin
      b_in = 3'(psd_pkg::MAX_BITS);
    end else begin
      b_in = bits_per_symbol;
    end
    step_ext = psd_pkg::X_W'({1'b0, point_step});
    x_init   = step_ext - (step_ext << b_in);
    d        = psd_pkg::X_W'(y) - x;
    pt_max   = psd_pkg::PT_W'((5'd1 << b_eff) - 5'd1);
    bit_last = psd_pkg::BIT_W'(b_eff - 3'd1);
    bit_pos  = psd_pkg::BIT_W'(b_eff - 3'd1 - {1'b0, bit_i});
    lab      = label_map[{pt, 2'b00} +: 4];
    lab_bit  = lab[bit_pos];
    score_rd = psd_pkg::acc_t'(score[pt]);
  end

  // shared multiplier
  always_comb begin
    unique case (state)
      psd_pkg::ST_MUL_LO: begin
        mul_a = d2[psd_pkg::AD_W-1:0];
        mul_b = psd_pkg::AD_W'(inv_two_sigma2);
      end
      psd_pkg::ST_MUL_HI: begin
        mul_a = d2[psd_pkg::PROD_W-1:psd_pkg::AD_W];
        mul_b = psd_pkg::AD_W'(inv_two_sigma2);
      end
      default: begin
        mul_a = ad;
        mul_b = ad;
      end
    endcase
    prod   = mul_a * mul_b;
    sum    = psd_pkg::SUM_W'(plo) + (psd_pkg::SUM_W'(phi) << psd_pkg::AD_W)
             + (psd_pkg::SUM_W'(1) << (psd_pkg::MET_SHIFT - 1));
    metric = sum[psd_pkg::MET_SHIFT +: psd_pkg::MET_W];
  end

  psd_max_star u_max_star (
    .a (lab_bit ? acc1 : acc0),
    .b (score_rd),
    .y (ms_y)
  );

  // final LLR of the current bit
  always_comb begin
    llr_wide = {acc0[psd_pkg::ACC_W-1], acc0} - {acc1[psd_pkg::ACC_W-1], acc1};
    lim_w    = (psd_pkg::ACC_W+1)'({1'b0, llr_limit});
    if (!have1) begin
      llr_sat = lim_w;
    end else if (!have0) begin
      llr_sat = -lim_w;
    end else if (llr_wide > lim_w) begin
      llr_sat = lim_w;
    end else if (llr_wide < -lim_w) begin
      llr_sat = -lim_w;
    end else begin
      llr_sat = llr_wide;
    end
    llr_out = code[bit_pos] ? -llr_sat[psd_pkg::LLR_W-1:0] : llr_sat[psd_pkg::LLR_W-1:0];
  end

  // sequencer
  always_comb begin
    state_next = state;
    pt_next    = pt;
    bit_i_next = bit_i;
    have0_next = have0;
    have1_next = have1;
    out_load   = 1'b0;
    s_tready   = 1'b0;
    unique case (state)
      psd_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = psd_pkg::ST_DIFF;
          pt_next    = '0;
        end
      end
      psd_pkg::ST_DIFF:   state_next = psd_pkg::ST_SQUARE;
      psd_pkg::ST_SQUARE: state_next = psd_pkg::ST_MUL_LO;
      psd_pkg::ST_MUL_LO: state_next = psd_pkg::ST_MUL_HI;
      psd_pkg::ST_MUL_HI: state_next = psd_pkg::ST_SCORE;
      psd_pkg::ST_SCORE: begin
        pt_next = pt + 1'b1;
        if (pt == pt_max) begin
          state_next = psd_pkg::ST_COMBINE;
          pt_next    = '0;
          bit_i_next = '0;
          have0_next = 1'b0;
          have1_next = 1'b0;
        end else begin
          state_next = psd_pkg::ST_DIFF;
        end
      end
      psd_pkg::ST_COMBINE: begin
        pt_next = pt + 1'b1;
        if (lab_bit) begin
          have1_next = 1'b1;
        end else begin
          have0_next = 1'b1;
        end
        if (pt == pt_max) begin
          state_next = psd_pkg::ST_EMIT;
        end
      end
      psd_pkg::ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          if (bit_i == bit_last) begin
            state_next = psd_pkg::ST_IDLE;
          end else begin
            state_next = psd_pkg::ST_COMBINE;
            bit_i_next = bit_i + 1'b1;
            pt_next    = '0;
            have0_next = 1'b0;
            have1_next = 1'b0;
          end
        end
      end
      default: state_next = psd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= psd_pkg::ST_IDLE;
      pt       <= '0;
      bit_i    <= '0;
      have0    <= 1'b0;
      have1    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      pt    <= pt_next;
      bit_i <= bit_i_next;
      have0 <= have0_next;
      have1 <= have1_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      psd_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          y     <= psd_pkg::Y_W'({s_tdata[psd_pkg::SAMPLE_W-1:0], 4'b0000});
          code  <= s_tdata[psd_pkg::SAMPLE_W +: psd_pkg::CODE_W];
          b_eff <= b_in;
          x     <= x_init;
        end
      end
      psd_pkg::ST_DIFF: begin
        ad <= d[psd_pkg::X_W-1] ? psd_pkg::AD_W'(-d) : psd_pkg::AD_W'(d);
        x  <= x + (step_ext <<< 1);
      end
      psd_pkg::ST_SQUARE: d2  <= prod;
      psd_pkg::ST_MUL_LO: plo <= prod;
      psd_pkg::ST_MUL_HI: phi <= prod;
      psd_pkg::ST_SCORE: score[pt] <= -psd_pkg::score_t'({1'b0, metric});
      psd_pkg::ST_COMBINE: begin
        if (lab_bit) begin
          acc1 <= have1 ? ms_y : score_rd;
        end else begin
          acc0 <= have0 ? ms_y : score_rd;
        end
      end
      psd_pkg::ST_EMIT: begin
        if (out_load) begin
          m_tdata <= llr_out;
          m_tuser <= bit_i;
          m_tlast <= (bit_i == bit_last);
        end
      end
      default: ;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == psd_pkg::ST_DIFF && pt == '0))
    else $error("accepted transaction did not start the point sweep");

  a_emit_has_points: assert property (@(posedge clk) disable iff (rst)
    (state == psd_pkg::ST_EMIT) |-> (have0 || have1))
    else $error("LLR emitted with no points combined");

  a_emit_bit_range: assert property (@(posedge clk) disable iff (rst)
    (state == psd_pkg::ST_EMIT) |-> ({1'b0, bit_i} < b_eff))
    else $error("bit index beyond symbol width");

endmodule

// ===== src/psd_max_star.sv =====
// Jacobian logarithm unit: max(a,b) plus table correction on |a-b|.
module psd_max_star (
  input  psd_pkg::acc_t a,
  input  psd_pkg::acc_t b,
  output psd_pkg::acc_t y
);

  logic signed [psd_pkg::ACC_W:0] diff;
  logic        [psd_pkg::ACC_W:0] mag;
  psd_pkg::acc_t                  mx;
  logic                           in_range;
  logic [psd_pkg::CORR_W-1:0]     corr;

  always_comb begin
    diff     = {a[psd_pkg::ACC_W-1], a} - {b[psd_pkg::ACC_W-1], b};
    mx       = diff[psd_pkg::ACC_W] ? b : a;
    mag      = diff[psd_pkg::ACC_W] ? -diff : diff;
    in_range = (mag >> (psd_pkg::CORR_SHIFT + psd_pkg::CORR_IDX_W)) == '0;
    corr     = in_range ?
               psd_pkg::corr_lookup(mag[psd_pkg::CORR_SHIFT +: psd_pkg::CORR_IDX_W]) : '0;
    y        = mx + psd_pkg::acc_t'({1'b0, corr});
  end

endmodule
